// ===== hdl/flfs_pkg.sv =====
// Shared types and constants for the fixed-length frame synchronizer.
`timescale 1ns / 1ps

package flfs_pkg;

   localparam int BYTE_W    = 8;
   localparam int IDX_W     = 6;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CFG_HEADER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_TAIL   = 1'd1;

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h72;
   localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h21;

   // controller -> datapath
   typedef struct packed {
      logic append;     // store the request byte at the end of the buffer
      logic scan_init;  // start rescan at the second stored byte
      logic emit_init;  // start frame readout at the first stored byte
      logic advance;    // step read pointer and offset
      logic scan_take;  // header found: new frame starts at read pointer
      logic clear;      // buffer empty
      logic load_out;   // load the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic accept_ok;  // byte is kept (buffer not empty or byte is header)
      logic fills;      // one byte short of a full frame
      logic tail_hit;   // request byte equals the tail value
      logic hdr_hit;    // read data equals the header value
      logic idx_last;   // offset at final frame position
      logic out_free;   // response register can take a new byte
   } status_type;

endpackage

// ===== hdl/flfs_if.sv =====
// Valid/ready channel interfaces for request bytes and frame responses.
`timescale 1ns / 1ps

interface flfs_req_if;
   import flfs_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface flfs_rsp_if;
   import flfs_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic [IDX_W-1:0]  byte_index;
   logic              last_of_frame;

   modport source (output valid, output frame_byte, output byte_index,
                   output last_of_frame, input ready);
   modport sink   (input valid, input frame_byte, input byte_index,
                   input last_of_frame, output ready);
endinterface

// ===== hdl/flfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module flfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/flfs_ctrl.sv =====
// Controller state machine: byte intake, rescan and frame readout sequencing.
`timescale 1ns / 1ps

module flfs_ctrl import flfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN_RD,
      SCAN_CMP,
      EMIT_RD,
      EMIT_LD
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      take;

   assign take = req_valid && ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (take && status.accept_ok) begin
               cmd.append = 1'b1;
               if (status.fills) begin
                  if (status.tail_hit) begin
                     cmd.emit_init = 1'b1;
                     state_in      = EMIT_RD;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = SCAN_RD;
                  end
               end
            end
         end
         SCAN_RD: begin
            state_in = SCAN_CMP;
         end
         SCAN_CMP: begin
            priority if (status.hdr_hit) begin
               cmd.scan_take = 1'b1;
               state_in      = IDLE;
            end else if (status.idx_last) begin
               cmd.clear = 1'b1;
               state_in  = IDLE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = SCAN_RD;
            end
         end
         EMIT_RD: begin
            state_in = EMIT_LD;
         end
         EMIT_LD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.idx_last) begin
                  cmd.clear = 1'b1;
                  state_in  = IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = EMIT_RD;
               end
            end
         end
         default: state_in = IDLE;
      endcase
      ready_in = (state_in == IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

// ===== hdl/flfs_dp.sv =====
// Datapath: ring buffer, pointers, settings registers and response register.
`timescale 1ns / 1ps

module flfs_dp import flfs_pkg::*; #(
   parameter int FRAME_LEN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   input  logic [BYTE_W-1:0]    rx_byte,
   input  logic                 rsp_ready,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_valid,
   output logic [BYTE_W-1:0]    frame_byte,
   output logic [IDX_W-1:0]     byte_index,
   output logic                 last_of_frame
);

   localparam int AW = $clog2(FRAME_LEN);
   localparam int CW = $clog2(FRAME_LEN + 1);
   localparam logic [AW-1:0] LAST_POS = AW'(FRAME_LEN - 1);
   localparam logic [AW:0]   LEN_W    = (AW+1)'(FRAME_LEN);

   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     rp_ff, rp_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] tail_ff, tail_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic              out_last_ff, out_last_in;

   logic [AW:0]       wsum;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     head_inc;
   logic [AW-1:0]     rp_inc;
   logic [BYTE_W-1:0] rd_data;

   // write slot is head + count, wrapped around the buffer
   assign wsum    = (AW+1)'(head_ff) + (AW+1)'(count_ff);
   assign wr_addr = (wsum >= LEN_W) ? AW'(wsum - LEN_W) : AW'(wsum);
   assign head_inc = (head_ff == LAST_POS) ? '0 : head_ff + 1'b1;
   assign rp_inc   = (rp_ff == LAST_POS) ? '0 : rp_ff + 1'b1;

   flfs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_LEN)
   ) u_ram (
      .clock (clock),
      .we    (cmd.append),
      .waddr (wr_addr),
      .wdata (rx_byte),
      .raddr (rp_ff),
      .rdata (rd_data)
   );

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      rp_in    = rp_ff;
      idx_in   = idx_ff;
      if (cmd.append) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.scan_init) begin
         rp_in  = head_inc;
         idx_in = AW'(1);
      end
      if (cmd.emit_init) begin
         rp_in  = head_ff;
         idx_in = '0;
      end
      if (cmd.advance) begin
         rp_in  = rp_inc;
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.scan_take) begin
         head_in  = rp_ff;
         count_in = CW'(FRAME_LEN) - CW'(idx_ff);
      end
      if (cmd.clear) begin
         count_in = '0;
      end
   end

   always_comb begin
      header_in = header_ff;
      tail_in   = tail_ff;
      if (csr_we && csr_index == CFG_HEADER) begin
         header_in = csr_wdata;
      end
      if (csr_we && csr_index == CFG_TAIL) begin
         tail_in = csr_wdata;
      end
   end

   always_comb begin
      out_byte_in  = out_byte_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.load_out) begin
         out_byte_in  = rd_data;
         out_idx_in   = IDX_W'(idx_ff);
         out_last_in  = (idx_ff == LAST_POS);
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rp_ff        <= '0;
         idx_ff       <= '0;
         header_ff    <= HEADER_RESET;
         tail_ff      <= TAIL_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         idx_ff       <= idx_in;
         header_ff    <= header_in;
         tail_ff      <= tail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

   assign status.accept_ok = (count_ff != '0) || (rx_byte == header_ff);
   assign status.fills     = (count_ff == CW'(FRAME_LEN - 1));
   assign status.tail_hit  = (rx_byte == tail_ff);
   assign status.hdr_hit   = (rd_data == header_ff);
   assign status.idx_last  = (idx_ff == LAST_POS);
   assign status.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign frame_byte    = out_byte_ff;
   assign byte_index    = out_idx_ff;
   assign last_of_frame = out_last_ff;

endmodule

// ===== hdl/fixed_length_frame_sync.sv =====
// Top level of the fixed-length frame synchronizer.
//
// Usage: received serial bytes enter on the req channel (valid/ready), one
// byte per request. Bytes are collected in a FRAME_LEN-deep ring buffer that
// always starts with the header byte; a byte arriving into an empty buffer
// that is not the header is dropped. Frame bytes leave on the rsp channel
// with their position and a last-byte flag.
// Flow: after a byte that does not complete a frame, the next request is
// taken in the following cycle. A completed frame with a matching tail is
// read out of the buffer RAM byte by byte (RAM read, then response load). A
// tail mismatch starts a rescan for the next header, a RAM read then a
// compare per stored byte; req_ready is low during readout and rescan. After
// the last frame byte is loaded, requests are taken again while that byte
// waits in the response register.
// Reset empties the buffer and restores header 0x72 and tail 0x21; the csr
// port (index 0 header, index 1 tail) is to be written by the user only while
// idle, which the block itself does not enforce. A stalled receiver holds the
// response register and pauses the readout.
`timescale 1ns / 1ps

module fixed_length_frame_sync import flfs_pkg::*; #(
   parameter int FRAME_LEN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   flfs_req_if.sink             req_if,
   flfs_rsp_if.source           rsp_if
);

   cmd_type    cmd;
   status_type status;

   flfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   flfs_dp #(
      .FRAME_LEN (FRAME_LEN)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rx_byte       (req_if.rx_byte),
      .rsp_ready     (rsp_if.ready),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_if.valid),
      .frame_byte    (rsp_if.frame_byte),
      .byte_index    (rsp_if.byte_index),
      .last_of_frame (rsp_if.last_of_frame)
   );

   // a response byte is only loaded into a free slot
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("response loaded while previous one still pending");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.append, cmd.scan_take, cmd.clear, cmd.advance}))
      else $error("conflicting buffer commands");

   a_last_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out && status.idx_last |=> rsp_if.valid && rsp_if.last_of_frame)
      else $error("final frame byte not flagged");

   // only a request completing a frame takes the block out of intake
   a_stay_ready: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && !(status.accept_ok && status.fills)
      |=> req_if.ready)
      else $error("intake stopped without a full frame");

endmodule

// ===== bench/flfs_frame_checker.sv =====
// Watches the frame synchronizer's channels, predicts frame output and checks each response.
`timescale 1ns / 1ps

module flfs_frame_checker import flfs_pkg::*; #(
   parameter int FRAME_LEN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   flfs_req_if                  req_if,
   flfs_rsp_if                  rsp_if,
   output int                   fail_count,
   output int                   bytes_owed
);

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic [IDX_W-1:0]  byte_index;
      logic              last_of_frame;
   } frame_beat_type;

   logic [BYTE_W-1:0] hdr_cfg;
   logic [BYTE_W-1:0] tail_cfg;
   logic [BYTE_W-1:0] held_bytes [FRAME_LEN];
   int                held_cnt;
   frame_beat_type    frame_owed [$];
   int                errs = 0;

   assign fail_count = errs;

   // One received byte into the frame store; queues a whole frame on a tail match.
   function automatic void absorb_rx_byte(input logic [BYTE_W-1:0] b);
      int             start;
      frame_beat_type beat;
      if (held_cnt == 0 && b != hdr_cfg) return;
      if (held_cnt < FRAME_LEN) begin
         held_bytes[held_cnt] = b;
         held_cnt++;
      end
      if (held_cnt < FRAME_LEN) return;
      if (held_bytes[FRAME_LEN-1] == tail_cfg) begin
         for (int i = 0; i < FRAME_LEN; i++) begin
            beat.frame_byte    = held_bytes[i];
            beat.byte_index    = IDX_W'(i);
            beat.last_of_frame = (i == FRAME_LEN - 1);
            frame_owed.push_back(beat);
         end
         held_cnt = 0;
         return;
      end
      // tail miss: drop the leading header, restart at the next header if any
      start = held_cnt;
      for (int i = 1; i < held_cnt; i++) begin
         if (start == held_cnt && held_bytes[i] == hdr_cfg) start = i;
      end
      for (int j = 0; j < held_cnt - start; j++) begin
         held_bytes[j] = held_bytes[j + start];
      end
      held_cnt = held_cnt - start;
   endfunction

   always @(posedge clock) begin : watch
      frame_beat_type want;
      if (reset) begin
         hdr_cfg  = HEADER_RESET;
         tail_cfg = TAIL_RESET;
         held_cnt = 0;
         frame_owed.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CFG_HEADER: hdr_cfg = csr_wdata;
               CFG_TAIL:   tail_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (frame_owed.size() == 0) begin
               $error("frame response with none pending: %s %0h %s %0d %s %0b",
                      "frame_byte", rsp_if.frame_byte, "byte_index", rsp_if.byte_index,
                      "last_of_frame", rsp_if.last_of_frame);
               errs++;
            end else begin
               want = frame_owed.pop_front();
               if (rsp_if.frame_byte !== want.frame_byte) begin
                  $error("frame_byte: expected %0h, got %0h", want.frame_byte, rsp_if.frame_byte);
                  errs++;
               end
               if (rsp_if.byte_index !== want.byte_index) begin
                  $error("byte_index: expected %0d, got %0d", want.byte_index, rsp_if.byte_index);
                  errs++;
               end
               if (rsp_if.last_of_frame !== want.last_of_frame) begin
                  $error("last_of_frame: expected %0b, got %0b",
                         want.last_of_frame, rsp_if.last_of_frame);
                  errs++;
               end
            end
         end
         if (req_if.valid && req_if.ready) absorb_rx_byte(req_if.rx_byte);
      end
      bytes_owed <= frame_owed.size();
   end

endmodule

// ===== bench/tb_fixed_length_frame_sync.sv =====
// Testbench top for the frame synchronizer: clock, reset, byte stimulus and the verdict.
`timescale 1ns / 1ps

module tb_fixed_length_frame_sync;
   import flfs_pkg::*;

   localparam int FRAME_LEN   = 64;
   localparam int SETTLE      = 2 * FRAME_LEN + 8;   // covers a full rescan
   localparam int PHASE_BYTES = 64;
   localparam int LIMIT_NS    = 600_000 * 12;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;
   logic [BYTE_W-1:0]    hdr_now;
   logic [BYTE_W-1:0]    tail_now;
   bit                   steady = 1'b0;
   int                   sent = 0;
   int                   fail_count;
   int                   bytes_owed;

   flfs_req_if req ();
   flfs_rsp_if rsp ();

   fixed_length_frame_sync #(.FRAME_LEN(FRAME_LEN)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req),
      .rsp_if    (rsp)
   );

   flfs_frame_checker #(.FRAME_LEN(FRAME_LEN)) frame_check (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_if     (req),
      .rsp_if     (rsp),
      .fail_count (fail_count),
      .bytes_owed (bytes_owed)
   );

   always #6 clock = ~clock;

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (!steady && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.rx_byte <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
   endtask

   task automatic send_frame(input bit good);
      logic [BYTE_W-1:0] b;
      send_byte(hdr_now);
      for (int i = 1; i < FRAME_LEN - 1; i++) begin
         b = BYTE_W'($urandom_range(0, 255));
         if (!good && $urandom_range(0, 9) == 0) b = hdr_now;   // header to resync on
         else if (b == hdr_now && $urandom_range(0, 3) != 0) b = ~b;
         send_byte(b);
      end
      send_byte(good ? tail_now : tail_now ^ BYTE_W'($urandom_range(1, 255)));
   endtask

   task automatic run_phase(input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] t);
      int first;
      int pick;
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CFG_HEADER;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= CFG_TAIL;
      csr_wdata <= t;
      @(posedge clock);
      csr_we   <= 1'b0;
      hdr_now  = h;
      tail_now = t;
      first = sent;
      while (sent - first < PHASE_BYTES) begin
         pick = $urandom_range(0, 7);
         if (pick < 4) send_frame(1'b1);
         else if (pick < 6) send_frame(1'b0);
         else repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
         if (!steady && $urandom_range(0, 4) == 0) drain();
      end
   endtask

   // response side: random stall bursts until the steady stretch
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!steady && $urandom_range(0, 7) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp.ready <= 1'b1;
      end
   end

   initial begin
      logic [BYTE_W-1:0] same;
      reset       <= 1'b1;
      req.valid   <= 1'b0;
      req.rx_byte <= '0;
      csr_we      <= 1'b0;
      csr_index   <= CFG_HEADER;
      csr_wdata   <= '0;
      hdr_now     = HEADER_RESET;
      tail_now    = TAIL_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty store drops non-header bytes, then a partial frame is left in place
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(TAIL_RESET);
      send_byte(HEADER_RESET);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HEADER_RESET);

      // header changes while the partial frame is still held
      run_phase(8'h00, 8'hFF);
      run_phase(8'hFF, 8'h00);
      run_phase(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      run_phase(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      same = BYTE_W'($urandom_range(0, 255));
      run_phase(same, same);
      steady = 1'b1;
      run_phase(HEADER_RESET, TAIL_RESET);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_fixed_length_frame_sync passed");
      end else begin
         $display("tb_fixed_length_frame_sync failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("tb_fixed_length_frame_sync failed");
      $finish;
   end

endmodule
